// File: rtl/core/ordered_list_store_unit_defines.svh
// assertion helpers for the list store top level
`ifndef ORDERED_LIST_STORE_UNIT_DEFINES_SVH
`define ORDERED_LIST_STORE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OLSU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define OLSU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/olsu_pkg.sv
package olsu_pkg;

  // fixed field widths of the ports
  localparam int CMD_W  = 3;
  localparam int POS_W  = 9;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    OP_GET    = 3'd0,
    OP_LOCATE = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_GET,
    S_SCAN,
    S_SHIFT,
    S_WRITE,
    S_RESULT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic setup_get;
    logic setup_scan;
    logic setup_ins;
    logic setup_del;
    logic walk;
    logic shift_wr;
    logic cap_read;
    logic set_found;
    logic wr_val;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic set_bad;
    logic set_full;
    logic load_out;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    op_e_t op;
    logic  pos_zero;
    logic  pos_gt_cnt;
    logic  pos_gt_cnt1;
    logic  pos_eq_cnt;
    logic  pos_eq_cnt1;
    logic  full;
    logic  cnt_zero;
    logic  pend;
    logic  hit;
    logic  walk_done;
    logic  out_free;
  } sts_t;

endpackage

// File: rtl/core/ordered_list_store_unit.sv
// Ordered list store: a list of up to DEPTH words of ELEM_WIDTH bits with
// 1-based positions, kept in a single-port-write, registered-read RAM.
// Each command transfer (get, locate, insert, delete, clear) gives exactly
// one result transfer with status, read value, found position and the list
// length after the command. Commands are handled one at a time; in_stall is
// high from the cycle after a transfer until the result is in the output
// register, which may still be waiting on out_stall while the next command
// is taken. Locate, insert and delete walk the entries they touch through
// the RAM at one read per cycle (the moves of insert and delete overlap
// each read with the write of the previous entry); the number of entries
// scanned or moved is at most DEPTH. No clearing pass is needed after
// reset: entries beyond the length are never read.
`include "ordered_list_store_unit_defines.svh"

module ordered_list_store_unit #(
  parameter int DEPTH      = 256,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [olsu_pkg::CMD_W-1:0]  in_cmd,
  input  logic [olsu_pkg::POS_W-1:0]  in_position,
  input  logic [olsu_pkg::DATA_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [olsu_pkg::STAT_W-1:0] out_status,
  output logic [olsu_pkg::DATA_W-1:0] out_read_value,
  output logic [olsu_pkg::POS_W-1:0]  out_found_position,
  output logic [olsu_pkg::POS_W-1:0]  out_list_length
);

  olsu_pkg::ctl_t ctl;
  olsu_pkg::sts_t sts;

  // sequencer
  olsu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // list storage and result path
  olsu_dp #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_cmd             (in_cmd),
    .in_position        (in_position),
    .in_value           (in_value),
    .ctl                (ctl),
    .sts                (sts),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

  // a command transfer always makes the block busy on the next cycle
  `OLSU_ASSERT_NXT(a_busy_after_transfer, clk, rst_n, in_valid && !in_stall, in_stall,
                   "not busy after command transfer")

  // results only load when the output register can take them
  `OLSU_ASSERT_IMP(a_load_when_free, clk, rst_n, ctl.load_out, sts.out_free,
                   "result loaded over a pending one")

  // a stalled result stays valid and unchanged
  `OLSU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_status) && $stable(out_read_value) && $stable(out_list_length),
                   "stalled result changed")

endmodule

// File: rtl/core/olsu_ram.sv
module olsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/olsu_ctrl.sv
module olsu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  olsu_pkg::sts_t   sts,
  output olsu_pkg::ctl_t   ctl
);

  olsu_pkg::state_t state_r;
  olsu_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= olsu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != olsu_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      olsu_pkg::S_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          state_nxt = olsu_pkg::S_CHECK;
        end
      end
      olsu_pkg::S_CHECK: begin
        state_nxt = olsu_pkg::S_RESULT;
        case (sts.op)
          olsu_pkg::OP_GET: begin
            if (sts.pos_zero || sts.pos_gt_cnt) begin
              ctl.set_bad = 1'b1;
            end else begin
              ctl.setup_get = 1'b1;
              state_nxt     = olsu_pkg::S_GET;
            end
          end
          olsu_pkg::OP_LOCATE: begin
            if (!sts.cnt_zero) begin
              ctl.setup_scan = 1'b1;
              state_nxt      = olsu_pkg::S_SCAN;
            end
          end
          olsu_pkg::OP_INSERT: begin
            if (sts.pos_zero || sts.pos_gt_cnt1) begin
              ctl.set_bad = 1'b1;
            end else if (sts.full) begin
              ctl.set_full = 1'b1;
            end else if (sts.pos_eq_cnt1) begin
              // append at the tail, nothing to move
              state_nxt = olsu_pkg::S_WRITE;
            end else begin
              ctl.setup_ins = 1'b1;
              state_nxt     = olsu_pkg::S_SHIFT;
            end
          end
          olsu_pkg::OP_DELETE: begin
            if (sts.pos_zero || sts.pos_gt_cnt) begin
              ctl.set_bad = 1'b1;
            end else if (sts.pos_eq_cnt) begin
              // drop the tail entry, nothing to move
              ctl.cnt_dec = 1'b1;
            end else begin
              ctl.setup_del = 1'b1;
              state_nxt     = olsu_pkg::S_SHIFT;
            end
          end
          olsu_pkg::OP_CLEAR: begin
            ctl.cnt_clr = 1'b1;
          end
          default: begin
          end
        endcase
      end
      olsu_pkg::S_GET: begin
        ctl.walk = 1'b1;
        if (sts.pend) begin
          ctl.cap_read = 1'b1;
          state_nxt    = olsu_pkg::S_RESULT;
        end
      end
      olsu_pkg::S_SCAN: begin
        ctl.walk = 1'b1;
        if (sts.hit) begin
          ctl.set_found = 1'b1;
          state_nxt     = olsu_pkg::S_RESULT;
        end else if (sts.walk_done) begin
          state_nxt = olsu_pkg::S_RESULT;
        end
      end
      olsu_pkg::S_SHIFT: begin
        ctl.walk     = 1'b1;
        ctl.shift_wr = 1'b1;
        if (sts.walk_done) begin
          if (sts.op == olsu_pkg::OP_INSERT) begin
            state_nxt = olsu_pkg::S_WRITE;
          end else begin
            ctl.cnt_dec = 1'b1;
            state_nxt   = olsu_pkg::S_RESULT;
          end
        end
      end
      olsu_pkg::S_WRITE: begin
        ctl.wr_val  = 1'b1;
        ctl.cnt_inc = 1'b1;
        state_nxt   = olsu_pkg::S_RESULT;
      end
      olsu_pkg::S_RESULT: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = olsu_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = olsu_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/olsu_dp.sv
module olsu_dp #(
  parameter int DEPTH      = 256,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [olsu_pkg::CMD_W-1:0]  in_cmd,
  input  logic [olsu_pkg::POS_W-1:0]  in_position,
  input  logic [olsu_pkg::DATA_W-1:0] in_value,
  input  olsu_pkg::ctl_t              ctl,
  output olsu_pkg::sts_t              sts,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [olsu_pkg::STAT_W-1:0] out_status,
  output logic [olsu_pkg::DATA_W-1:0] out_read_value,
  output logic [olsu_pkg::POS_W-1:0]  out_found_position,
  output logic [olsu_pkg::POS_W-1:0]  out_list_length
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > olsu_pkg::POS_W) ? CW : olsu_pkg::POS_W) + 1;

  // latched command
  olsu_pkg::op_e_t              op_r, op_nxt;
  logic [olsu_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [ELEM_WIDTH-1:0]        val_r, val_nxt;

  // list length and walk control
  logic [CW-1:0]                count_r, count_nxt;
  logic [CW-1:0]                rem_r, rem_nxt;
  logic [AW-1:0]                rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]                wr_addr_r, wr_addr_nxt;
  logic [AW-1:0]                dat_addr_r, dat_addr_nxt;
  logic                         up_r, up_nxt;
  logic                         pend_r, pend_nxt;

  // result under construction
  olsu_pkg::status_t            res_status_r, res_status_nxt;
  logic [olsu_pkg::DATA_W-1:0]  res_read_r, res_read_nxt;
  logic [olsu_pkg::POS_W-1:0]   res_found_r, res_found_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  olsu_pkg::status_t            out_status_r, out_status_nxt;
  logic [olsu_pkg::DATA_W-1:0]  out_read_r, out_read_nxt;
  logic [olsu_pkg::POS_W-1:0]   out_found_r, out_found_nxt;
  logic [olsu_pkg::POS_W-1:0]   out_len_r, out_len_nxt;

  // extended arithmetic
  logic [XW-1:0]                pos_x, cnt_x, pos_m1_x, cnt_m1_x;
  logic [XW-1:0]                rem_ins_x, rem_del_x, found_x;
  logic [63:0]                  rdata_x;

  // memory port
  logic                         issue;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [ELEM_WIDTH-1:0]        ram_wdata;
  logic [ELEM_WIDTH-1:0]        ram_rdata;

  assign pos_x     = XW'(pos_r);
  assign cnt_x     = XW'(count_r);
  assign pos_m1_x  = pos_x - XW'(1);
  assign cnt_m1_x  = cnt_x - XW'(1);
  assign rem_ins_x = cnt_x - pos_x + XW'(1);
  assign rem_del_x = cnt_x - pos_x;
  assign found_x   = XW'(dat_addr_r) + XW'(1);
  assign rdata_x   = 64'(ram_rdata);

  // one read per cycle while walking and entries remain
  assign issue = ctl.walk && (rem_r != '0);

  // write either a moved entry or the inserted value
  assign ram_we    = (ctl.shift_wr && pend_r) || ctl.wr_val;
  assign ram_waddr = ctl.wr_val ? pos_m1_x[AW-1:0] : wr_addr_r;
  assign ram_wdata = ctl.wr_val ? val_r : ram_rdata;

  olsu_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // status toward the controller
  always_comb begin
    sts.op          = op_r;
    sts.pos_zero    = (pos_r == '0);
    sts.pos_gt_cnt  = (pos_x > cnt_x);
    sts.pos_gt_cnt1 = (pos_x > (cnt_x + XW'(1)));
    sts.pos_eq_cnt  = (pos_x == cnt_x);
    sts.pos_eq_cnt1 = (pos_x == (cnt_x + XW'(1)));
    sts.full        = (cnt_x == XW'(DEPTH));
    sts.cnt_zero    = (count_r == '0);
    sts.pend        = pend_r;
    sts.hit         = pend_r && (ram_rdata == val_r);
    sts.walk_done   = (rem_r == '0) && !pend_r;
    sts.out_free    = !out_valid_r || !out_stall;
  end

  // next values
  always_comb begin
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    rd_addr_nxt    = rd_addr_r;
    wr_addr_nxt    = wr_addr_r;
    dat_addr_nxt   = dat_addr_r;
    up_nxt         = up_r;
    pend_nxt       = issue;
    res_status_nxt = res_status_r;
    res_read_nxt   = res_read_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_read_nxt   = out_read_r;
    out_found_nxt  = out_found_r;
    out_len_nxt    = out_len_r;

    // capture the command transfer
    if (ctl.latch) begin
      op_nxt         = olsu_pkg::op_e_t'(in_cmd);
      pos_nxt        = in_position;
      val_nxt        = ELEM_WIDTH'(in_value);
      res_status_nxt = olsu_pkg::STAT_OK;
      res_read_nxt   = '0;
      res_found_nxt  = '0;
    end

    // walk setup per command
    if (ctl.setup_get) begin
      rd_addr_nxt = pos_m1_x[AW-1:0];
      rem_nxt     = CW'(1);
      up_nxt      = 1'b1;
    end
    if (ctl.setup_scan) begin
      rd_addr_nxt = '0;
      rem_nxt     = count_r;
      up_nxt      = 1'b1;
    end
    if (ctl.setup_ins) begin
      rd_addr_nxt = cnt_m1_x[AW-1:0];
      wr_addr_nxt = cnt_x[AW-1:0];
      rem_nxt     = rem_ins_x[CW-1:0];
      up_nxt      = 1'b0;
    end
    if (ctl.setup_del) begin
      rd_addr_nxt = pos_x[AW-1:0];
      wr_addr_nxt = pos_m1_x[AW-1:0];
      rem_nxt     = rem_del_x[CW-1:0];
      up_nxt      = 1'b1;
    end

    // read address steps with each issued read
    if (issue) begin
      rd_addr_nxt  = up_r ? (rd_addr_r + AW'(1)) : (rd_addr_r - AW'(1));
      rem_nxt      = rem_r - CW'(1);
      dat_addr_nxt = rd_addr_r;
    end

    // write address steps with each moved entry
    if (ctl.shift_wr && pend_r) begin
      wr_addr_nxt = up_r ? (wr_addr_r + AW'(1)) : (wr_addr_r - AW'(1));
    end

    // result fields
    if (ctl.cap_read) begin
      res_read_nxt = rdata_x[olsu_pkg::DATA_W-1:0];
    end
    if (ctl.set_found) begin
      res_found_nxt = found_x[olsu_pkg::POS_W-1:0];
    end
    if (ctl.set_bad) begin
      res_status_nxt = olsu_pkg::STAT_BAD_POS;
    end
    if (ctl.set_full) begin
      res_status_nxt = olsu_pkg::STAT_FULL;
    end

    // list length
    if (ctl.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end
    if (ctl.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
    if (ctl.cnt_clr) begin
      count_nxt = '0;
    end

    // output register
    if (ctl.load_out) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_read_nxt   = res_read_r;
      out_found_nxt  = res_found_r;
      out_len_nxt    = cnt_x[olsu_pkg::POS_W-1:0];
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    rem_r        <= rem_nxt;
    rd_addr_r    <= rd_addr_nxt;
    wr_addr_r    <= wr_addr_nxt;
    dat_addr_r   <= dat_addr_nxt;
    up_r         <= up_nxt;
    res_status_r <= res_status_nxt;
    res_read_r   <= res_read_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_read_r   <= out_read_nxt;
    out_found_r  <= out_found_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_value     = out_read_r;
  assign out_found_position = out_found_r;
  assign out_list_length    = out_len_r;

endmodule

// File: test/tb_ordered_list_store_unit.sv
module tb_ordered_list_store_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = 256;
  localparam int CMD_TOP = (1 << olsu_pkg::CMD_W) - 1;
  localparam int POS_TOP = (1 << olsu_pkg::POS_W) - 1;
  localparam int MIX_LEN_CAP = 48;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int PRINT_CAP = 50;

  // one result of the list store
  typedef struct {
    olsu_pkg::status_t              status;
    logic [olsu_pkg::DATA_W-1:0]    read_value;
    logic [olsu_pkg::POS_W-1:0]     found_position;
    logic [olsu_pkg::POS_W-1:0]     list_length;
  } list_reply_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [olsu_pkg::CMD_W-1:0]  in_cmd = '0;
  logic [olsu_pkg::POS_W-1:0]  in_position = '0;
  logic [olsu_pkg::DATA_W-1:0] in_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [olsu_pkg::STAT_W-1:0] out_status;
  logic [olsu_pkg::DATA_W-1:0] out_read_value;
  logic [olsu_pkg::POS_W-1:0]  out_found_position;
  logic [olsu_pkg::POS_W-1:0]  out_list_length;

  // predicted contents of the list
  logic [olsu_pkg::DATA_W-1:0] list_words [LIST_DEPTH];
  int                          list_len = 0;

  list_reply_t pending_replies [$];
  int          fail_count = 0;
  int          sender_gap_pct = 0;
  int          receiver_stall_pct = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  ordered_list_store_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

  always #5 clk = ~clk;

  // apply one command to the predicted list and return its result
  function automatic list_reply_t apply_command(logic [olsu_pkg::CMD_W-1:0] op,
                                                logic [olsu_pkg::POS_W-1:0] pos,
                                                logic [olsu_pkg::DATA_W-1:0] val);
    list_reply_t reply;
    int p;
    reply.status = olsu_pkg::STAT_OK;
    reply.read_value = '0;
    reply.found_position = '0;
    p = pos;
    case (op)
      olsu_pkg::OP_GET: begin
        if (p == 0 || p > list_len) reply.status = olsu_pkg::STAT_BAD_POS;
        else reply.read_value = list_words[p-1];
      end
      olsu_pkg::OP_LOCATE: begin
        for (int k = 0; k < list_len; k++)
          if (reply.found_position == 0 && list_words[k] == val)
            reply.found_position = olsu_pkg::POS_W'(k + 1);
      end
      olsu_pkg::OP_INSERT: begin
        if (p == 0 || p > list_len + 1) reply.status = olsu_pkg::STAT_BAD_POS;
        else if (list_len >= LIST_DEPTH) reply.status = olsu_pkg::STAT_FULL;
        else begin
          for (int k = list_len; k > p - 1; k--) list_words[k] = list_words[k-1];
          list_words[p-1] = val;
          list_len++;
        end
      end
      olsu_pkg::OP_DELETE: begin
        if (p == 0 || p > list_len) reply.status = olsu_pkg::STAT_BAD_POS;
        else begin
          for (int k = p; k < list_len; k++) list_words[k-1] = list_words[k];
          list_len--;
        end
      end
      olsu_pkg::OP_CLEAR: list_len = 0;
      default: ;
    endcase
    reply.list_length = olsu_pkg::POS_W'(list_len);
    return reply;
  endfunction

  // mostly legal positions, with edge and noise positions mixed in
  function automatic logic [olsu_pkg::POS_W-1:0] pick_position(int upper);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 14) return olsu_pkg::POS_W'(upper + 1);
    if (r < 20 || upper == 0) return olsu_pkg::POS_W'($urandom_range(0, POS_TOP));
    return olsu_pkg::POS_W'($urandom_range(1, upper));
  endfunction

  // values from a small pool give duplicates for locate
  function automatic logic [olsu_pkg::DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return olsu_pkg::DATA_W'($urandom_range(0, 3));
    if (r < 35) return {olsu_pkg::DATA_W{1'b1}} - olsu_pkg::DATA_W'($urandom_range(0, 3));
    return $urandom;
  endfunction

  task automatic report_mismatch(string field, logic [olsu_pkg::DATA_W-1:0] seen,
                                 logic [olsu_pkg::DATA_W-1:0] wanted);
    if (fail_count < PRINT_CAP)
      $display("%0t: mismatch on %s: got %h, wanted %h", $realtime, field, seen, wanted);
    fail_count++;
  endtask

  // offer one command and hold it until the transfer
  task automatic send_cmd(logic [olsu_pkg::CMD_W-1:0] op, logic [olsu_pkg::POS_W-1:0] pos,
                          logic [olsu_pkg::DATA_W-1:0] val);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= op;
    in_position <= pos;
    in_value <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_replies.push_back(apply_command(op, pos, val));
  endtask

  // empty list, shifts on insert and delete, bad positions, unknown codes
  task automatic run_directed_checks();
    send_cmd(olsu_pkg::OP_GET, 9'd1, '0);
    send_cmd(olsu_pkg::OP_DELETE, 9'd1, '0);
    send_cmd(olsu_pkg::OP_LOCATE, '0, '0);
    send_cmd(olsu_pkg::OP_INSERT, 9'd0, 32'h1);
    send_cmd(olsu_pkg::OP_INSERT, 9'd2, 32'h1);
    send_cmd(olsu_pkg::OP_INSERT, 9'd1, 32'h0);
    send_cmd(olsu_pkg::OP_INSERT, 9'd2, 32'hFFFF_FFFF);
    send_cmd(olsu_pkg::OP_INSERT, 9'd1, 32'h8000_0001);
    send_cmd(olsu_pkg::OP_INSERT, 9'd3, 32'h5A5A_5A5A);
    send_cmd(olsu_pkg::OP_INSERT, 9'd5, 32'h0);
    send_cmd(olsu_pkg::OP_GET, 9'd0, '0);
    send_cmd(olsu_pkg::OP_GET, 9'd1, '0);
    send_cmd(olsu_pkg::OP_GET, 9'd5, '0);
    send_cmd(olsu_pkg::OP_GET, 9'd6, '0);
    send_cmd(olsu_pkg::OP_GET, olsu_pkg::POS_W'(POS_TOP), '0);
    send_cmd(olsu_pkg::OP_LOCATE, '0, 32'h0);
    send_cmd(olsu_pkg::OP_LOCATE, '0, 32'hFFFF_FFFF);
    send_cmd(olsu_pkg::OP_LOCATE, '0, 32'h1234_5678);
    send_cmd(olsu_pkg::OP_DELETE, 9'd0, '0);
    send_cmd(olsu_pkg::OP_DELETE, 9'd6, '0);
    send_cmd(olsu_pkg::OP_DELETE, 9'd1, '0);
    send_cmd(olsu_pkg::OP_DELETE, 9'd4, '0);
    for (int c = int'(olsu_pkg::OP_CLEAR) + 1; c <= CMD_TOP; c++)
      send_cmd(olsu_pkg::CMD_W'(c), olsu_pkg::POS_W'($urandom), $urandom);
    send_cmd(olsu_pkg::OP_CLEAR, '0, '0);
    send_cmd(olsu_pkg::OP_GET, 9'd1, '0);
  endtask

  // random command mix with the list kept short
  task automatic run_random_mix(int n_items);
    int r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        send_cmd(olsu_pkg::CMD_W'($urandom_range(int'(olsu_pkg::OP_CLEAR) + 1, CMD_TOP)),
                 olsu_pkg::POS_W'($urandom), $urandom);
      else if (r < 5)
        send_cmd(olsu_pkg::OP_CLEAR, olsu_pkg::POS_W'($urandom), $urandom);
      else if (r < 25)
        send_cmd(olsu_pkg::OP_GET, pick_position(list_len), $urandom);
      else if (r < 40) begin
        if (list_len > 0 && $urandom_range(0, 99) < 60)
          send_cmd(olsu_pkg::OP_LOCATE, olsu_pkg::POS_W'($urandom),
                   list_words[$urandom_range(0, list_len - 1)]);
        else
          send_cmd(olsu_pkg::OP_LOCATE, olsu_pkg::POS_W'($urandom), pick_value());
      end else if (r < 70 && list_len < MIX_LEN_CAP)
        send_cmd(olsu_pkg::OP_INSERT, pick_position(list_len + 1), pick_value());
      else
        send_cmd(olsu_pkg::OP_DELETE, pick_position(list_len), $urandom);
    end
  endtask

  // fill the list to capacity, then hit the full and top-position cases
  task automatic run_fill_to_capacity();
    send_cmd(olsu_pkg::OP_CLEAR, '0, '0);
    while (list_len < LIST_DEPTH)
      send_cmd(olsu_pkg::OP_INSERT, olsu_pkg::POS_W'($urandom_range(1, list_len + 1)),
               $urandom);
    send_cmd(olsu_pkg::OP_INSERT, 9'd1, $urandom);
    send_cmd(olsu_pkg::OP_INSERT, olsu_pkg::POS_W'(LIST_DEPTH + 1), $urandom);
    send_cmd(olsu_pkg::OP_INSERT, olsu_pkg::POS_W'(LIST_DEPTH + 2), $urandom);
    send_cmd(olsu_pkg::OP_INSERT, 9'd0, $urandom);
    send_cmd(olsu_pkg::OP_GET, olsu_pkg::POS_W'(LIST_DEPTH), '0);
    send_cmd(olsu_pkg::OP_GET, olsu_pkg::POS_W'(LIST_DEPTH + 1), '0);
    send_cmd(olsu_pkg::OP_LOCATE, '0, list_words[LIST_DEPTH-1]);
    send_cmd(olsu_pkg::OP_LOCATE, '0, $urandom);
    send_cmd(olsu_pkg::OP_DELETE, olsu_pkg::POS_W'(LIST_DEPTH + 1), '0);
    send_cmd(olsu_pkg::OP_DELETE, olsu_pkg::POS_W'(LIST_DEPTH), '0);
    send_cmd(olsu_pkg::OP_INSERT, olsu_pkg::POS_W'(LIST_DEPTH), 32'hFFFF_FFFF);
    send_cmd(olsu_pkg::OP_LOCATE, '0, 32'hFFFF_FFFF);
    send_cmd(olsu_pkg::OP_DELETE, 9'd1, '0);
    send_cmd(olsu_pkg::OP_GET, 9'd1, '0);
    send_cmd(olsu_pkg::OP_CLEAR, '0, '0);
  endtask

  // receiver holds off while commands keep coming, so the input backs up
  task automatic run_output_backpressure();
    hold_left = HOLD_OFF_CYCLES;
    run_random_mix(16);
  endtask

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    list_reply_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("result with no command pending", out_status, '0);
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_read_value !== want.read_value)
          report_mismatch("read_value", out_read_value, want.read_value);
        if (out_found_position !== want.found_position)
          report_mismatch("found_position", out_found_position, want.found_position);
        if (out_list_length !== want.list_length)
          report_mismatch("list_length", out_list_length, want.list_length);
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    sender_gap_pct = 16;
    receiver_stall_pct = 63;
    run_directed_checks();
    run_random_mix(530);

    // sender idles heavily, receiver lightly
    sender_gap_pct = 63;
    receiver_stall_pct = 16;
    run_random_mix(530);

    // no idling on either side
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    run_fill_to_capacity();
    run_output_backpressure();
    run_random_mix(530);

    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
